// File: rtl/psr_pkg.sv
`timescale 1ns / 1ps
// types and constants of the polyline stitch resampler
// used by psr_sqdiv and polyline_stitch_resampler

package psr_pkg;

    localparam int COORD_W  = 20;
    localparam int DIFF_W   = 21;
    localparam int LEN_W    = 13;
    localparam int L2_W     = 42;
    localparam int KS_W     = 19;
    localparam int LEN_FRAC = 10;
    localparam int RAD_W    = 62;
    localparam int ROOT_W   = 31;
    localparam int REM_W    = 33;
    localparam int RES_W    = 32;
    localparam int STEP_W   = 5;

    localparam logic [LEN_W-1:0] STITCH_LEN_RST = 13'd768;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sd524287;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -20'sd524288;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_vertex;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] stitch_x;
        logic signed [COORD_W-1:0] stitch_y;
        logic                      run_end;
        logic                      truncated;
    } stitch_t;

    typedef enum logic {
        SD_SQRT = 1'b0,
        SD_DIV  = 1'b1
    } sd_op_t;

    typedef struct packed {
        logic   start;
        sd_op_t op;
    } sd_cmd_t;

endpackage

// File: rtl/psr_sqdiv.sv
`timescale 1ns / 1ps
// shared iterative unit: integer square root, two bits a cycle, or
// restoring division, one quotient bit a cycle; depends on psr_pkg

module psr_sqdiv #(
    parameter int QW = 23,
    parameter int NW = 53
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psr_pkg::sd_cmd_t              cmd,
    input  logic [psr_pkg::RAD_W-1:0]     radicand,
    input  logic [NW-1:0]                 numer,
    input  logic [psr_pkg::ROOT_W-1:0]    denom,
    output logic                          done,
    output logic [psr_pkg::RES_W-1:0]     result
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    psr_pkg::sd_op_t               op_reg, op_next;
    logic [psr_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic [psr_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [psr_pkg::RES_W-1:0]     res_reg, res_next;
    logic [psr_pkg::RAD_W-1:0]     sh_reg, sh_next;
    logic [psr_pkg::ROOT_W-1:0]    den_reg, den_next;

    logic [psr_pkg::REM_W+1:0]     r2, trial;
    logic [psr_pkg::REM_W:0]       r1, den_ext;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        r2        = {rem_reg, sh_reg[psr_pkg::RAD_W-1 -: 2]};
        trial     = {2'b00, res_reg[psr_pkg::ROOT_W-1:0], 2'b01};
        r1        = {rem_reg, sh_reg[psr_pkg::RAD_W-1]};
        den_ext   = {{(psr_pkg::REM_W + 1 - psr_pkg::ROOT_W){1'b0}}, den_reg};
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            res_next  = '0;
            den_next  = denom;
            if (cmd.op == psr_pkg::SD_SQRT)
            begin
                rem_next = '0;
                sh_next  = radicand;
                cnt_next = psr_pkg::STEP_W'(psr_pkg::ROOT_W);
            end
            else
            begin
                rem_next = psr_pkg::REM_W'(numer[NW-1:QW]);
                sh_next  = {numer[QW-1:0], {(psr_pkg::RAD_W - QW){1'b0}}};
                cnt_next = psr_pkg::STEP_W'(QW);
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == psr_pkg::SD_SQRT)
            begin
                sh_next = {sh_reg[psr_pkg::RAD_W-3:0], 2'b00};
                if (r2 >= trial)
                begin
                    rem_next = psr_pkg::REM_W'(r2 - trial);
                    res_next = {res_reg[psr_pkg::RES_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = psr_pkg::REM_W'(r2);
                    res_next = {res_reg[psr_pkg::RES_W-2:0], 1'b0};
                end
            end
            else
            begin
                sh_next = {sh_reg[psr_pkg::RAD_W-2:0], 1'b0};
                if (r1 >= den_ext)
                begin
                    rem_next = psr_pkg::REM_W'(r1 - den_ext);
                    res_next = {res_reg[psr_pkg::RES_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = psr_pkg::REM_W'(r1);
                    res_next = {res_reg[psr_pkg::RES_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == psr_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= psr_pkg::SD_SQRT;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running operation");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cmd.start)
        else $error("start while busy");

    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("busy with zero step count");

endmodule

// File: rtl/polyline_stitch_resampler.sv
`timescale 1ns / 1ps
// polyline stitch resampler top: sequencer, shared multiplier, output register
// depends on psr_pkg and psr_sqdiv
//
//   channel   direction  handshake               payload
//   vertex    in         vertex_valid/stall      psr_pkg::vertex_t
//   stitch    out        stitch_valid/stall      psr_pkg::stitch_t
//   cfg       in         cfg_we                  cfg_data (stitch length)
//
// an item is accepted, then the two squares and the count loop (one multiply-compare
// per step) run, and the start vertex is sent; if any point falls inside the segment,
// the root and the two quotients follow in the shared unit, then the points one by one,
// and one more output for an end vertex.
// reset clears the held vertex and sets the stitch length to 768.
// a stalled stitch output holds the sequencer; vertex_stall is high while busy.

module polyline_stitch_resampler #(
    parameter int MAX_STEPS = 62,
    parameter int FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             vertex_valid,
    output logic                             vertex_stall,
    input  psr_pkg::vertex_t                 vertex,
    output logic                             stitch_valid,
    input  logic                             stitch_stall,
    output psr_pkg::stitch_t                 stitch,
    input  logic                             cfg_we,
    input  logic [psr_pkg::LEN_W-1:0]        cfg_data
);

    localparam int CW    = $clog2(MAX_STEPS + 1);
    localparam int QW    = FRAC_BITS + 15;
    localparam int NW    = FRAC_BITS + 45;
    localparam int ACC_W = FRAC_BITS + 24;
    localparam int R_W   = ACC_W - FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF = ACC_W'((1 << FRAC_BITS) >> 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_CNT, S_START, S_SQRT, S_SQRT_WAIT,
        S_NUMX, S_DIVX_WAIT, S_NUMY, S_DIVY_WAIT, S_PTS, S_END
    } state_t;

    state_t state_reg, state_next;

    logic [psr_pkg::LEN_W-1:0]           slen_reg, slen_next;
    logic                                have_prev_reg, have_prev_next;
    logic signed [psr_pkg::COORD_W-1:0]  prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [psr_pkg::COORD_W-1:0]  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic                                last_reg, last_next;
    logic signed [psr_pkg::DIFF_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [psr_pkg::L2_W-1:0]            l2_reg, l2_next;
    logic [psr_pkg::KS_W-1:0]            ks_reg, ks_next;
    logic [CW-1:0]                       count_reg, count_next, k_reg, k_next;
    logic                                trunc_reg, trunc_next;
    logic [psr_pkg::ROOT_W-1:0]          lq_reg, lq_next;
    logic signed [QW:0]                  jx_reg, jx_next, jy_reg, jy_next;
    logic signed [ACC_W-1:0]             ax_reg, ax_next, ay_reg, ay_next;
    psr_pkg::stitch_t                    out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    logic [psr_pkg::DIFF_W-1:0]          mag_x, mag_y, mul_a, mul_b;
    logic [psr_pkg::L2_W-1:0]            prod;
    logic [NW-1:0]                       numer;
    psr_pkg::sd_cmd_t                    sd_cmd;
    logic                                sd_done;
    logic [psr_pkg::RES_W-1:0]           sd_res;
    logic                                out_free;
    logic signed [ACC_W-1:0]             vx_sum, vy_sum;
    logic signed [R_W-1:0]               rx, ry;
    logic signed [psr_pkg::COORD_W-1:0]  px, py;
    logic signed [QW:0]                  q_pos;

    assign mag_x = dx_reg[psr_pkg::DIFF_W-1] ? psr_pkg::DIFF_W'(-dx_reg)
                                             : psr_pkg::DIFF_W'(dx_reg);
    assign mag_y = dy_reg[psr_pkg::DIFF_W-1] ? psr_pkg::DIFF_W'(-dy_reg)
                                             : psr_pkg::DIFF_W'(dy_reg);

    // one multiplier, operands picked by state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQX:   begin mul_a = mag_x; mul_b = mag_x; end
            S_SQY:   begin mul_a = mag_y; mul_b = mag_y; end
            S_CNT:   begin
                         mul_a = psr_pkg::DIFF_W'(ks_reg);
                         mul_b = psr_pkg::DIFF_W'(ks_reg);
                     end
            S_NUMX:  begin mul_a = mag_x; mul_b = psr_pkg::DIFF_W'(slen_reg); end
            S_NUMY:  begin mul_a = mag_y; mul_b = psr_pkg::DIFF_W'(slen_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign numer = NW'({prod[33:0], {(FRAC_BITS + psr_pkg::LEN_FRAC){1'b0}}})
                 + NW'(lq_reg >> 1);

    assign sd_cmd.start = (state_reg == S_SQRT) || (state_reg == S_NUMX)
                       || (state_reg == S_NUMY);
    assign sd_cmd.op    = (state_reg == S_SQRT) ? psr_pkg::SD_SQRT : psr_pkg::SD_DIV;

    psr_sqdiv #(.QW(QW), .NW(NW)) u_sqdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (sd_cmd),
        .radicand ({l2_reg, {(2 * psr_pkg::LEN_FRAC){1'b0}}}),
        .numer    (numer),
        .denom    (lq_reg),
        .done     (sd_done),
        .result   (sd_res)
    );

    assign q_pos = (QW + 1)'(sd_res[QW-1:0]);

    // round half up, then clamp to the coordinate range
    always_comb
    begin
        vx_sum = ax_reg + $signed(HALF);
        vy_sum = ay_reg + $signed(HALF);
        rx = R_W'(vx_sum >>> FRAC_BITS);
        ry = R_W'(vy_sum >>> FRAC_BITS);
        if (rx > R_W'(psr_pkg::COORD_MAX))
            px = psr_pkg::COORD_MAX;
        else if (rx < R_W'(psr_pkg::COORD_MIN))
            px = psr_pkg::COORD_MIN;
        else
            px = psr_pkg::COORD_W'(rx);
        if (ry > R_W'(psr_pkg::COORD_MAX))
            py = psr_pkg::COORD_MAX;
        else if (ry < R_W'(psr_pkg::COORD_MIN))
            py = psr_pkg::COORD_MIN;
        else
            py = psr_pkg::COORD_W'(ry);
    end

    assign out_free = !out_valid_reg || !stitch_stall;

    always_comb
    begin
        state_next     = state_reg;
        slen_next      = slen_reg;
        have_prev_next = have_prev_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        last_next      = last_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        l2_next        = l2_reg;
        ks_next        = ks_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        trunc_next     = trunc_reg;
        lq_next        = lq_reg;
        jx_next        = jx_reg;
        jy_next        = jy_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && stitch_stall;

        if (cfg_we && cfg_data != '0)
            slen_next = cfg_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (vertex_valid)
                begin
                    cur_x_next = vertex.vertex_x;
                    cur_y_next = vertex.vertex_y;
                    last_next  = vertex.last_vertex;
                    dx_next    = psr_pkg::DIFF_W'(vertex.vertex_x) - psr_pkg::DIFF_W'(prev_x_reg);
                    dy_next    = psr_pkg::DIFF_W'(vertex.vertex_y) - psr_pkg::DIFF_W'(prev_y_reg);
                    trunc_next = 1'b0;
                    count_next = '0;
                    if (have_prev_reg)
                        state_next = S_SQX;
                    else if (vertex.last_vertex)
                        state_next = S_END;
                    else
                    begin
                        prev_x_next    = vertex.vertex_x;
                        prev_y_next    = vertex.vertex_y;
                        have_prev_next = 1'b1;
                    end
                end
            end
            S_SQX:
            begin
                l2_next    = prod;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                l2_next    = l2_reg + prod;
                ks_next    = psr_pkg::KS_W'(slen_reg);
                state_next = S_CNT;
            end
            S_CNT:
            begin
                // ks holds (count+1) times the stitch length
                if (count_reg == CW'(MAX_STEPS))
                begin
                    trunc_next = prod < l2_reg;
                    state_next = S_START;
                end
                else if (prod < l2_reg)
                begin
                    count_next = count_reg + 1'b1;
                    ks_next    = ks_reg + psr_pkg::KS_W'(slen_reg);
                end
                else
                    state_next = S_START;
            end
            S_START:
            begin
                if (out_free)
                begin
                    out_next.stitch_x  = prev_x_reg;
                    out_next.stitch_y  = prev_y_reg;
                    out_next.run_end   = !last_reg && count_reg == '0;
                    out_next.truncated = trunc_reg;
                    out_valid_next     = 1'b1;
                    if (count_reg != '0)
                        state_next = S_SQRT;
                    else if (last_reg)
                        state_next = S_END;
                    else
                    begin
                        prev_x_next = cur_x_reg;
                        prev_y_next = cur_y_reg;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_SQRT:
                state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:
            begin
                if (sd_done)
                begin
                    lq_next    = sd_res[psr_pkg::ROOT_W-1:0];
                    state_next = S_NUMX;
                end
            end
            S_NUMX:
                state_next = S_DIVX_WAIT;
            S_DIVX_WAIT:
            begin
                if (sd_done)
                begin
                    jx_next    = dx_reg[psr_pkg::DIFF_W-1] ? -q_pos : q_pos;
                    state_next = S_NUMY;
                end
            end
            S_NUMY:
                state_next = S_DIVY_WAIT;
            S_DIVY_WAIT:
            begin
                if (sd_done)
                begin
                    jy_next    = dy_reg[psr_pkg::DIFF_W-1] ? -q_pos : q_pos;
                    ax_next    = (ACC_W'(prev_x_reg) <<< FRAC_BITS) + ACC_W'(jx_reg);
                    ay_next    = (ACC_W'(prev_y_reg) <<< FRAC_BITS)
                               + ACC_W'(dy_reg[psr_pkg::DIFF_W-1] ? -q_pos : q_pos);
                    k_next     = CW'(1);
                    state_next = S_PTS;
                end
            end
            S_PTS:
            begin
                if (out_free)
                begin
                    out_next.stitch_x  = px;
                    out_next.stitch_y  = py;
                    out_next.run_end   = !last_reg && k_reg == count_reg;
                    out_next.truncated = trunc_reg;
                    out_valid_next     = 1'b1;
                    ax_next            = ax_reg + ACC_W'(jx_reg);
                    ay_next            = ay_reg + ACC_W'(jy_reg);
                    k_next             = k_reg + 1'b1;
                    if (k_reg == count_reg)
                    begin
                        if (last_reg)
                            state_next = S_END;
                        else
                        begin
                            prev_x_next = cur_x_reg;
                            prev_y_next = cur_y_reg;
                            state_next  = S_IDLE;
                        end
                    end
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    out_next.stitch_x  = cur_x_reg;
                    out_next.stitch_y  = cur_y_reg;
                    out_next.run_end   = 1'b1;
                    out_next.truncated = trunc_reg;
                    out_valid_next     = 1'b1;
                    have_prev_next     = 1'b0;
                    prev_x_next        = '0;
                    prev_y_next        = '0;
                    state_next         = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slen_reg      <= psr_pkg::STITCH_LEN_RST;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            k_reg         <= '0;
            trunc_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slen_reg      <= slen_next;
            have_prev_reg <= have_prev_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            trunc_reg     <= trunc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        last_reg  <= last_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        l2_reg    <= l2_next;
        ks_reg    <= ks_next;
        lq_reg    <= lq_next;
        jx_reg    <= jx_next;
        jy_reg    <= jy_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        out_reg   <= out_next;
    end

    assign vertex_stall = state_reg != S_IDLE;
    assign stitch_valid = out_valid_reg;
    assign stitch       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_STEPS))
        else $error("point count above limit");

    a_trunc_full: assert property (@(posedge clk) disable iff (!rst_n)
        trunc_reg |-> count_reg == CW'(MAX_STEPS))
        else $error("truncated without a full count");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PTS |-> (k_reg != '0 && k_reg <= count_reg))
        else $error("point index out of range");

    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sd_done |-> (state_reg == S_SQRT_WAIT || state_reg == S_DIVX_WAIT
                     || state_reg == S_DIVY_WAIT))
        else $error("unit finished while not awaited");

endmodule
